/* design/sddd_pkg.sv */
`timescale 1ns / 1ps

package sddd_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DiffW  = 23;

  // Shifted year (year + 400, less one for January and February).
  localparam int unsigned ShYearW = 15;
  // Day number of one date; only differences between two carry meaning.
  localparam int unsigned DayNumW = 23;
  // Quotient of a year by 100 never exceeds 167.
  localparam int unsigned CentW   = 8;
  // Product width of a year times the reciprocal of 100.
  localparam int unsigned ProdW   = 30;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for every x below 43690.
  localparam int unsigned Recip100      = 20972;
  localparam int unsigned Recip100Shift = 21;
  localparam int unsigned YearBias      = 400;
  localparam int unsigned DaysPerYear   = 365;

  localparam logic signed [DiffW+1:0] DiffMax = (DiffW+2)'(4194303);
  localparam logic signed [DiffW+1:0] DiffMin = -(DiffW+2)'(4194304);

  // Control that the top level hands to each date lane.
  typedef struct packed {
    logic load_s1;
    logic load_s2;
  } stage_ctl_t;

  // Length of a month in days; zero for a month code outside January to December.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    begin
      unique case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        4'd2:                                       len = leap ? 5'd29 : 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Days from the first of March to the first of the given month, with the
  // year taken to start in March.
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] month);
    logic [8:0] off;
    begin
      unique case (month)
        4'd3:    off = 9'd0;
        4'd4:    off = 9'd31;
        4'd5:    off = 9'd61;
        4'd6:    off = 9'd92;
        4'd7:    off = 9'd122;
        4'd8:    off = 9'd153;
        4'd9:    off = 9'd184;
        4'd10:   off = 9'd214;
        4'd11:   off = 9'd245;
        4'd12:   off = 9'd275;
        4'd1:    off = 9'd306;
        4'd2:    off = 9'd337;
        default: off = 9'd0;
      endcase
      return off;
    end
  endfunction

endpackage

/* design/sddd_in_if.sv */
`timescale 1ns / 1ps

interface sddd_in_if;
  logic                           valid;
  logic                           ready;
  logic [sddd_pkg::YearW-1:0]     first_year;
  logic [sddd_pkg::MonthW-1:0]    first_month;
  logic [sddd_pkg::DayW-1:0]      first_day;
  logic [sddd_pkg::YearW-1:0]     second_year;
  logic [sddd_pkg::MonthW-1:0]    second_month;
  logic [sddd_pkg::DayW-1:0]      second_day;
  logic                           count_end_day;

  modport source (
    output valid, first_year, first_month, first_day,
           second_year, second_month, second_day, count_end_day,
    input  ready
  );

  modport sink (
    input  valid, first_year, first_month, first_day,
           second_year, second_month, second_day, count_end_day,
    output ready
  );
endinterface

/* design/sddd_out_if.sv */
`timescale 1ns / 1ps

interface sddd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sddd_pkg::DiffW-1:0] day_difference;
  logic                             date_error;

  modport source (
    output valid, day_difference, date_error,
    input  ready
  );

  modport sink (
    input  valid, day_difference, date_error,
    output ready
  );
endinterface

/* design/signed_date_day_difference_unit.sv */
// An accepted item reaches the output through three register stages.
// Throughput: one item per cycle while the output is ready; each stage holds
// one item and moves on whenever the stage after it is empty or moving.
// Reset (rst_ni low, asynchronous) empties every stage; no result is valid
// until a new item has passed through the pipeline.
`timescale 1ns / 1ps

module signed_date_day_difference_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  sddd_in_if.sink           dates_i,
  sddd_out_if.source        result_o
);

  // Valid bits of the three stages. Each stage loads when it is empty or when
  // its content is leaving in the same cycle, so that a bubble anywhere in the
  // pipeline is squeezed out and a stall at the output only holds the stages
  // that are actually full.
  logic v1_q, v2_q, v3_q;
  logic load1, load2, load3;
  sddd_pkg::stage_ctl_t ctl;

  // The end day flag has no work to do until the last stage, so it simply
  // travels alongside the date lanes.
  logic end1_q, end2_q;

  logic [sddd_pkg::DayNumW-1:0] first_dnum, second_dnum;
  logic                         first_err, second_err;

  always_comb begin
    load3         = !v3_q || result_o.ready;
    load2         = !v2_q || load3;
    load1         = !v1_q || load2;
    ctl.load_s1   = load1;
    ctl.load_s2   = load2;
    dates_i.ready = load1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (load1) begin
        v1_q <= dates_i.valid;
      end
      if (load2) begin
        v2_q <= v1_q;
      end
      if (load3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      end1_q <= dates_i.count_end_day;
    end
    if (load2) begin
      end2_q <= end1_q;
    end
  end

  // Two identical lanes, one for each date: range check and day number.
  sddd_datenum u_first (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .year_i  (dates_i.first_year),
    .month_i (dates_i.first_month),
    .day_i   (dates_i.first_day),
    .dnum_o  (first_dnum),
    .err_o   (first_err)
  );

  sddd_datenum u_second (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .year_i  (dates_i.second_year),
    .month_i (dates_i.second_month),
    .day_i   (dates_i.second_day),
    .dnum_o  (second_dnum),
    .err_o   (second_err)
  );

  // The last stage is also the output register.
  sddd_diff u_diff (
    .clk_i         (clk_i),
    .load_i        (load3),
    .first_dnum_i  (first_dnum),
    .second_dnum_i (second_dnum),
    .first_err_i   (first_err),
    .second_err_i  (second_err),
    .count_end_i   (end2_q),
    .diff_o        (result_o.day_difference),
    .err_o         (result_o.date_error)
  );

  assign result_o.valid = v3_q;

  // An item with a bad date always reports a difference of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.date_error |-> result_o.day_difference == '0)
    else $error("date error reported with a non-zero difference");

  // A result only appears when the middle stage held an item in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(v2_q))
    else $error("result appeared without an item in the middle stage");

  // An empty first stage always takes a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> dates_i.ready)
    else $error("input refused while the first stage is empty");

  // A full first stage that cannot move on must refuse the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && !result_o.ready |-> !dates_i.ready)
    else $error("input taken while the whole pipeline is stalled");

endmodule

/* design/sddd_datenum.sv */
`timescale 1ns / 1ps

// One date lane: checks the date and turns it into a day number over two stages.
module sddd_datenum (
  input  logic                            clk_i,
  input  sddd_pkg::stage_ctl_t            ctl_i,
  input  logic [sddd_pkg::YearW-1:0]      year_i,
  input  logic [sddd_pkg::MonthW-1:0]     month_i,
  input  logic [sddd_pkg::DayW-1:0]       day_i,
  output logic [sddd_pkg::DayNumW-1:0]    dnum_o,
  output logic                            err_o
);

  logic [sddd_pkg::ShYearW-1:0] sh_year_d, sh_year_q;
  logic [sddd_pkg::ProdW-1:0]   sh_prod, yr_prod;
  logic [sddd_pkg::CentW-1:0]   sh_cent_q, yr_cent_q;
  logic [sddd_pkg::YearW-1:0]   year_q;
  logic [sddd_pkg::MonthW-1:0]  month_q;
  logic [sddd_pkg::DayW-1:0]    day_q;

  logic [sddd_pkg::YearW-1:0]   yr_rem;
  logic                         leap;
  logic [sddd_pkg::DayW-1:0]    mlen;
  logic                         date_ok;
  logic [sddd_pkg::DayNumW-1:0] dnum_d, dnum_q;
  logic                         err_q;

  // Stage 1: shift the year so that the year starts in March, and take both
  // the shifted and the plain year apart into centuries.
  always_comb begin
    sh_year_d = sddd_pkg::ShYearW'(year_i) + sddd_pkg::ShYearW'(sddd_pkg::YearBias)
                - ((month_i <= 4'd2) ? sddd_pkg::ShYearW'(1) : '0);
    sh_prod   = sddd_pkg::ProdW'(sh_year_d) * sddd_pkg::ProdW'(sddd_pkg::Recip100);
    yr_prod   = sddd_pkg::ProdW'(year_i) * sddd_pkg::ProdW'(sddd_pkg::Recip100);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s1) begin
      sh_year_q <= sh_year_d;
      sh_cent_q <= sh_prod[sddd_pkg::Recip100Shift +: sddd_pkg::CentW];
      yr_cent_q <= yr_prod[sddd_pkg::Recip100Shift +: sddd_pkg::CentW];
      year_q    <= year_i;
      month_q   <= month_i;
      day_q     <= day_i;
    end
  end

  // Stage 2: leap year rule, range check and the closed-form day number.
  always_comb begin
    yr_rem  = year_q - sddd_pkg::YearW'(yr_cent_q) * sddd_pkg::YearW'(100);
    leap    = ((year_q[1:0] == 2'd0) && (yr_rem != '0)) ||
              ((yr_rem == '0) && (yr_cent_q[1:0] == 2'd0));
    mlen    = sddd_pkg::month_days(month_q, leap);
    date_ok = (day_q != '0) && (day_q <= mlen);
    dnum_d  = sddd_pkg::DayNumW'(sh_year_q) * sddd_pkg::DayNumW'(sddd_pkg::DaysPerYear)
              + sddd_pkg::DayNumW'(sh_year_q >> 2)
              - sddd_pkg::DayNumW'(sh_cent_q)
              + sddd_pkg::DayNumW'(sh_cent_q >> 2)
              + sddd_pkg::DayNumW'(sddd_pkg::month_offset(month_q))
              + sddd_pkg::DayNumW'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s2) begin
      dnum_q <= dnum_d;
      err_q  <= !date_ok;
    end
  end

  assign dnum_o = dnum_q;
  assign err_o  = err_q;

endmodule

/* design/sddd_diff.sv */
`timescale 1ns / 1ps

// Final stage: subtract the day numbers, apply the end day, saturate, or give zero on a bad date.
module sddd_diff (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [sddd_pkg::DayNumW-1:0]        first_dnum_i,
  input  logic [sddd_pkg::DayNumW-1:0]        second_dnum_i,
  input  logic                                first_err_i,
  input  logic                                second_err_i,
  input  logic                                count_end_i,
  output logic signed [sddd_pkg::DiffW-1:0]   diff_o,
  output logic                                err_o
);

  logic signed [sddd_pkg::DiffW+1:0] raw, adj;
  logic signed [sddd_pkg::DiffW-1:0] diff_d, diff_q;
  logic                              err_d, err_q;

  always_comb begin
    raw = $signed({2'b00, second_dnum_i}) - $signed({2'b00, first_dnum_i});
    if (count_end_i) begin
      adj = raw[sddd_pkg::DiffW+1] ? raw - (sddd_pkg::DiffW+2)'(1)
                                   : raw + (sddd_pkg::DiffW+2)'(1);
    end else begin
      adj = raw;
    end
    err_d = first_err_i || second_err_i;
    priority if (err_d) begin
      diff_d = '0;
    end else if (adj > sddd_pkg::DiffMax) begin
      diff_d = sddd_pkg::DiffMax[sddd_pkg::DiffW-1:0];
    end else if (adj < sddd_pkg::DiffMin) begin
      diff_d = sddd_pkg::DiffMin[sddd_pkg::DiffW-1:0];
    end else begin
      diff_d = adj[sddd_pkg::DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= diff_d;
      err_q  <= err_d;
    end
  end

  assign diff_o = diff_q;
  assign err_o  = err_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sddd_pkg::*;

  // One pair of dates as it is offered to the block.
  typedef struct packed {
    logic [YearW-1:0]  first_year;
    logic [MonthW-1:0] first_month;
    logic [DayW-1:0]   first_day;
    logic [YearW-1:0]  second_year;
    logic [MonthW-1:0] second_month;
    logic [DayW-1:0]   second_day;
    logic              count_end_day;
  } date_pair_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic signed [DiffW-1:0] day_difference;
    logic                    date_error;
  } day_result_t;

  // A single calendar date, used when random pairs are built.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } cal_date_t;

  localparam int unsigned PairW = $bits(date_pair_t);

  // Bounds of the 23-bit signed difference; wider spans are clamped to these.
  localparam longint SpanMax = 4194303;
  localparam longint SpanMin = -4194304;

  logic clk;
  logic rst_n;

  sddd_in_if  dates_if ();
  sddd_out_if result_if ();

  signed_date_day_difference_unit i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .dates_i  (dates_if),
    .result_o (result_if)
  );

  // Results predicted for accepted items, oldest first.
  day_result_t expected_day_diffs[$];
  int unsigned mismatch_count;
  // While set, neither side of the block inserts idle cycles.
  bit          steady_flow;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic of the predictor.
  // ---------------------------------------------------------------------------

  // Gregorian rule, applied to every year including year zero.
  function automatic bit is_leap(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  // Days in a month; zero for a month code outside January to December.
  function automatic int unsigned days_in_month(input int unsigned year,
                                                input int unsigned month);
    case (month)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(year) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(input int unsigned year, input int unsigned month,
                                    input int unsigned day);
    int unsigned len;
    len = days_in_month(year, month);
    return (len != 0) && (day >= 1) && (day <= len);
  endfunction

  // Serial day count with the year taken to begin in March, so that the leap
  // day falls at the end of the year. The bias of 400 years keeps every
  // quotient positive; only differences of two counts carry meaning.
  function automatic longint day_count(input int unsigned year, input int unsigned month,
                                       input int unsigned day);
    longint yy;
    longint mm;
    yy = longint'(year) + 400;
    mm = longint'(month);
    if (mm <= 2) begin
      yy = yy - 1;
      mm = mm + 12;
    end
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * (mm - 3) + 2) / 5
           + longint'(day);
  endfunction

  // Expected result for one date pair. A bad month or day in either date
  // gives the error flag and a zero difference; otherwise the signed span
  // is taken, widened by one day away from zero when the end day counts,
  // and clamped to the output range.
  function automatic day_result_t predict_difference(input date_pair_t p);
    day_result_t r;
    longint      span;
    r.day_difference = '0;
    r.date_error     = 1'b1;
    if (!date_valid(p.first_year, p.first_month, p.first_day) ||
        !date_valid(p.second_year, p.second_month, p.second_day)) begin
      return r;
    end
    span = day_count(p.second_year, p.second_month, p.second_day)
           - day_count(p.first_year, p.first_month, p.first_day);
    if (p.count_end_day) begin
      span = (span >= 0) ? span + 1 : span - 1;
    end
    if (span > SpanMax) begin
      span = SpanMax;
    end
    if (span < SpanMin) begin
      span = SpanMin;
    end
    r.day_difference = span[DiffW-1:0];
    r.date_error     = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers.
  // ---------------------------------------------------------------------------

  // Idle length: none for half the picks, often short, now and then a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // Years are mostly in the usual calendar range, with some from the whole
  // 14-bit field and some at the century and leap boundaries.
  function automatic logic [YearW-1:0] random_year();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return YearW'($urandom_range(1, 9999));
    end else if (r < 85) begin
      return YearW'($urandom_range(0, (1 << YearW) - 1));
    end
    case ($urandom_range(0, 9))
      0:       return YearW'(0);
      1:       return YearW'(1);
      2:       return YearW'(100);
      3:       return YearW'(400);
      4:       return YearW'(1900);
      5:       return YearW'(2000);
      6:       return YearW'(2100);
      7:       return YearW'(9999);
      8:       return YearW'(10000);
      default: return YearW'((1 << YearW) - 1);
    endcase
  endfunction

  // A well-formed date in the given year; the last day of the month is
  // favoured so that month ends and the leap day turn up often.
  function automatic cal_date_t random_valid_date(input logic [YearW-1:0] year);
    cal_date_t   d;
    int unsigned len;
    d.year  = year;
    d.month = MonthW'($urandom_range(1, 12));
    len     = days_in_month(year, d.month);
    if ($urandom_range(0, 99) < 15) begin
      d.day = DayW'(len);
    end else begin
      d.day = DayW'($urandom_range(1, len));
    end
    return d;
  endfunction

  // A pair of well-formed dates; the second is often in the same or a
  // nearby year so that short spans of both signs are common.
  function automatic date_pair_t random_valid_pair();
    date_pair_t       p;
    cal_date_t        a;
    cal_date_t        b;
    logic [YearW-1:0] y2;
    int unsigned      r;
    a = random_valid_date(random_year());
    r = $urandom_range(0, 99);
    if (r < 30) begin
      y2 = a.year;
    end else if (r < 50) begin
      if ($urandom_range(0, 1)) begin
        y2 = a.year + YearW'($urandom_range(0, 3));
      end else begin
        y2 = a.year - YearW'($urandom_range(0, 3));
      end
    end else begin
      y2 = random_year();
    end
    b = random_valid_date(y2);
    p.first_year    = a.year;
    p.first_month   = a.month;
    p.first_day     = a.day;
    p.second_year   = b.year;
    p.second_month  = b.month;
    p.second_day    = b.day;
    p.count_end_day = $urandom_range(0, 1);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender and receiver.
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the block takes it; the expected
  // result is queued at the edge of acceptance. Valid stays high into the
  // next call when no gap follows, so back-to-back items need no second
  // assignment within the same step.
  task automatic send_dates(input date_pair_t p);
    int unsigned gap;
    dates_if.valid         <= 1'b1;
    dates_if.first_year    <= p.first_year;
    dates_if.first_month   <= p.first_month;
    dates_if.first_day     <= p.first_day;
    dates_if.second_year   <= p.second_year;
    dates_if.second_month  <= p.second_month;
    dates_if.second_day    <= p.second_day;
    dates_if.count_end_day <= p.count_end_day;
    do begin
      @(posedge clk);
    end while (dates_if.ready !== 1'b1);
    expected_day_diffs.push_back(predict_difference(p));
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      dates_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pair(input int unsigned y1, input int unsigned m1, input int unsigned d1,
                           input int unsigned y2, input int unsigned m2, input int unsigned d2,
                           input bit end_day);
    date_pair_t p;
    p.first_year    = YearW'(y1);
    p.first_month   = MonthW'(m1);
    p.first_day     = DayW'(d1);
    p.second_year   = YearW'(y2);
    p.second_month  = MonthW'(m2);
    p.second_day    = DayW'(d2);
    p.count_end_day = end_day;
    send_dates(p);
  endtask

  // Waits on the result handshake alone until every queued result is in.
  task automatic wait_drained();
    while (expected_day_diffs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input day_result_t got,
                                 input day_result_t want);
    mismatch_count++;
    $display("%0t: %s: got difference %0d error %0b, expected difference %0d error %0b",
             $realtime, what, got.day_difference, got.date_error,
             want.day_difference, want.date_error);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked pairs: equal dates with and without the end day, the leap
  // day in leap, non-leap, century and four-century years, year zero, the
  // widest spans that saturate in both directions, and bad months and days
  // in either date.
  task automatic test_directed_dates();
    send_pair(2024, 1, 1, 2024, 1, 1, 1'b0);
    send_pair(2024, 1, 1, 2024, 1, 1, 1'b1);
    send_pair(2024, 3, 1, 2024, 2, 29, 1'b1);
    send_pair(2000, 2, 29, 2000, 3, 1, 1'b0);
    send_pair(1900, 2, 29, 1900, 3, 1, 1'b0);
    send_pair(2023, 2, 28, 2023, 3, 1, 1'b1);
    send_pair(2023, 1, 1, 2023, 2, 29, 1'b0);
    send_pair(2100, 2, 29, 2400, 2, 29, 1'b0);
    send_pair(2400, 2, 29, 2100, 2, 28, 1'b1);
    send_pair(0, 2, 29, 0, 3, 1, 1'b0);
    send_pair(1, 1, 1, 9999, 12, 31, 1'b1);
    send_pair(9999, 12, 31, 1, 1, 1, 1'b1);
    send_pair(0, 1, 1, 16383, 12, 31, 1'b0);
    send_pair(16383, 12, 31, 0, 1, 1, 1'b1);
    send_pair(16383, 15, 31, 2000, 1, 1, 1'b0);
    send_pair(2000, 1, 1, 2000, 0, 1, 1'b0);
    send_pair(2000, 1, 1, 2000, 13, 1, 1'b1);
    send_pair(2000, 1, 0, 2000, 1, 1, 1'b0);
    send_pair(2021, 3, 31, 2021, 4, 31, 1'b0);
    send_pair(2021, 12, 31, 2022, 1, 1, 1'b0);
    send_pair(2022, 1, 1, 2021, 12, 31, 1'b0);
    send_pair(0, 0, 0, 16383, 15, 31, 1'b1);
    send_pair(16383, 2, 29, 16383, 2, 28, 1'b0);
    send_pair(16383, 12, 31, 16383, 12, 31, 1'b1);
  endtask

  // Well-formed pairs with random content.
  task automatic test_random_valid(input int unsigned count);
    repeat (count) send_dates(random_valid_pair());
  endtask

  // Fully random fields, and well-formed pairs with one field broken.
  task automatic test_random_noise(input int unsigned count);
    date_pair_t  p;
    int unsigned len;
    repeat (count) begin
      if ($urandom_range(0, 1)) begin
        p = date_pair_t'(PairW'({$urandom, $urandom}));
      end else begin
        p = random_valid_pair();
        case ($urandom_range(0, 3))
          0: p.first_month  = ($urandom_range(0, 1)) ? MonthW'(0)
                                                     : MonthW'($urandom_range(13, 15));
          1: p.second_month = ($urandom_range(0, 1)) ? MonthW'(0)
                                                     : MonthW'($urandom_range(13, 15));
          2: begin
            len = days_in_month(p.first_year, p.first_month);
            p.first_day = (len < 31 && $urandom_range(0, 1)) ?
                          DayW'($urandom_range(len + 1, 31)) : DayW'(0);
          end
          default: begin
            len = days_in_month(p.second_year, p.second_month);
            p.second_day = (len < 31 && $urandom_range(0, 1)) ?
                           DayW'($urandom_range(len + 1, 31)) : DayW'(0);
          end
        endcase
      end
      send_dates(p);
    end
  endtask

  // The sender stops until the block has delivered everything, then resumes.
  task automatic test_drain_pause();
    repeat (40) send_dates(random_valid_pair());
    dates_if.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    repeat (40) send_dates(random_valid_pair());
  endtask

  // A stretch with neither side idling, to fill every pipeline stage.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (150) send_dates(random_valid_pair());
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, stimulus and the end of the run.
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    mismatch_count = 0;
    steady_flow    = 1'b0;
    rst_n          = 1'b0;
    dates_if.valid         <= 1'b0;
    dates_if.first_year    <= '0;
    dates_if.first_month   <= '0;
    dates_if.first_day     <= '0;
    dates_if.second_year   <= '0;
    dates_if.second_month  <= '0;
    dates_if.second_day    <= '0;
    dates_if.count_end_day <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_dates();
    test_random_valid(700);
    test_drain_pause();
    test_random_noise(350);
    test_back_to_back();
    test_random_valid(400);

    dates_if.valid <= 1'b0;
    wait_drained();
    // Let the three pipeline stages settle, so that a stray result shows up.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side ready: bursts of acceptance broken by stalls of random
  // length, with no stalls while the steady stretch runs.
  initial begin
    int unsigned gap;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) begin
      @(posedge clk);
    end
    forever begin
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Each accepted result is compared with the oldest expectation. Signals
  // are read just after the edge, before any of this step's updates land,
  // so they hold the values that the flops saw.
  initial begin
    day_result_t got;
    day_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        got.day_difference = result_if.day_difference;
        got.date_error     = result_if.date_error;
        if (expected_day_diffs.size() == 0) begin
          want = '0;
          report_mismatch("result with no item outstanding", got, want);
        end else begin
          want = expected_day_diffs.pop_front();
          if (got.day_difference !== want.day_difference) begin
            report_mismatch("day difference", got, want);
          end
          if (got.date_error !== want.date_error) begin
            report_mismatch("date error flag", got, want);
          end
        end
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
design/sddd_pkg.sv
design/sddd_in_if.sv
design/sddd_out_if.sv
design/sddd_datenum.sv
design/sddd_diff.sv
design/signed_date_day_difference_unit.sv
verif/testbench.sv
